@@ src/sbd_pkg.sv @@
// shared types and constants for the selective boundary dilate block
// no dependencies; used by every module in src
package sbd_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int WIDTH_RESET    = 1024;
    localparam int HEIGHT_RESET   = 1024;
    localparam int WIDTH_FIELD_W  = 11;
    localparam int HEIGHT_FIELD_W = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 13;
    localparam int QUEUE_DEPTH    = 4;
    localparam int WIN_SIZE       = 9;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        logic       func;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       was_replaced;
        logic       last_of_frame;
    } t_out;

    // line buffer pair at one column
    typedef struct packed {
        t_rgb older;
        t_rgb newer;
    } t_pair;

    // one emitting window plus its edge clamps and end-of-frame flag
    typedef struct packed {
        t_rgb [WIN_SIZE-1:0] win;
        logic                x_first;
        logic                x_last;
        logic                y_first;
        logic                y_last;
        logic                last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

@@ src/selective_boundary_dilate_3x3_core.sv @@
// Selective boundary dilate, 3x3 window over a raster RGB stream. One item
// (pixel or drain) is taken every clock while o_in_stall is low; a result
// appears image_width+1 items behind its pixel, and the first image_width+1
// items of a frame give none. The line buffer is read at the accepting edge,
// the window update enters the job queue when it has room, and the pick then
// goes into the output register, raising o_out_valid. The input side stalls
// only when the four-entry job queue is full, which happens only after the
// output side stalls. The user writes registers through the cfg port only
// while the block is idle, which it does not enforce. A write restarts the
// frame, buffer contents are kept. No clearing pass is needed after reset.
// depends on sbd_pkg, sbd_front, sbd_queue, sbd_back
module selective_boundary_dilate_3x3_core #(
    parameter int MAX_WIDTH  = sbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sbd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // register write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // pixel beats in
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  sbd_pkg::t_in                   i_in,
    // result beats out
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output sbd_pkg::t_out                  o_out
);

    logic            w_push, w_pop, w_head_valid;
    sbd_pkg::t_job   w_job, w_head;
    sbd_pkg::t_qstat w_qstat;

    // registers are plain flops, always writable
    assign o_cfg_ready = 1'b1;

    // counters, line buffers, window and edge flags
    sbd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_in_stall  (o_in_stall),
        .i_qstat     (w_qstat),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    // decouples the stall of the two sides
    sbd_queue #(
        .DEPTH (sbd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_job        (w_job),
        .i_pop        (w_pop),
        .o_stat       (w_qstat),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    // neighbor pick and output register
    sbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out),
        .i_out_stall  (i_out_stall)
    );

    // no job is pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qstat.full)
        else $error("job pushed into full queue");

    // no job is taken from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_qstat.empty)
        else $error("job popped from empty queue");

    // input stalls only with the queue full and a result held at the output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (w_qstat.full && o_out_valid))
        else $error("input stalled without a full queue");

endmodule

@@ src/sbd_front.sv @@
// front part: counters, line buffers, 3x3 window and edge flags
// depends on sbd_pkg
module sbd_front #(
    parameter int MAX_WIDTH  = sbd_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sbd_pkg::MAX_HEIGHT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_in_valid,
    input  sbd_pkg::t_in                       i_in,
    output logic                               o_in_stall,
    input  sbd_pkg::t_qstat                    i_qstat,
    output logic                               o_push,
    output sbd_pkg::t_job                      o_job
);

    localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int HW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int W_RST = (sbd_pkg::WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH
                                                              : sbd_pkg::WIDTH_RESET;
    localparam int H_RST = (sbd_pkg::HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT
                                                                : sbd_pkg::HEIGHT_RESET;

    sbd_pkg::t_pair r_mem [MAX_WIDTH];

    logic [CW-1:0] r_w_m1;
    logic [HW-1:0] r_h_m1;
    logic [CW-1:0] r_in_col;
    logic [1:0]    r_rows;
    logic [CW-1:0] r_out_col;
    logic [HW-1:0] r_out_row;

    logic          r_s1_valid;
    logic [CW-1:0] r_s1_addr;
    sbd_pkg::t_rgb r_s1_pix;
    logic          r_s1_emit;
    logic          r_s1_xf, r_s1_xl, r_s1_yf, r_s1_yl, r_s1_last;
    sbd_pkg::t_pair r_rd;

    sbd_pkg::t_rgb [sbd_pkg::WIN_SIZE-1:0] r_win;
    sbd_pkg::t_rgb [sbd_pkg::WIN_SIZE-1:0] n_win;

    logic [CW-1:0] n_w_m1;
    logic [HW-1:0] n_h_m1;
    logic [sbd_pkg::WIDTH_FIELD_W-1:0]  cfg_w;
    logic [sbd_pkg::HEIGHT_FIELD_W-1:0] cfg_h;
    logic           s1_adv, acc, emit, x_last, y_last, last, bypass;
    sbd_pkg::t_rgb  pix;
    sbd_pkg::t_pair wb;

    assign cfg_w = i_cfg_data[sbd_pkg::WIDTH_FIELD_W-1:0];
    assign cfg_h = i_cfg_data[sbd_pkg::HEIGHT_FIELD_W-1:0];

    // clamp register values to 1..max, kept as value minus one
    always_comb begin
        if (cfg_w == '0) begin
            n_w_m1 = '0;
        end else if (int'(cfg_w) > MAX_WIDTH) begin
            n_w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            n_w_m1 = CW'(cfg_w - 1'b1);
        end
        if (cfg_h == '0) begin
            n_h_m1 = '0;
        end else if (int'(cfg_h) > MAX_HEIGHT) begin
            n_h_m1 = HW'(MAX_HEIGHT - 1);
        end else begin
            n_h_m1 = HW'(cfg_h - 1'b1);
        end
    end

    assign s1_adv     = r_s1_valid && (!r_s1_emit || !i_qstat.full);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign acc        = i_in_valid && !o_in_stall;

    assign emit   = (r_rows == 2'd2) || ((r_rows == 2'd1) && (r_in_col != '0));
    assign x_last = (r_out_col == r_w_m1);
    assign y_last = (r_out_row == r_h_m1);
    assign last   = emit && x_last && y_last;

    // drain item enters as a black pixel
    assign pix = i_in.func ? '0 : {i_in.in_red, i_in.in_green, i_in.in_blue};

    assign wb.older = r_rd.newer;
    assign wb.newer = r_s1_pix;
    assign bypass   = s1_adv && (r_s1_addr == r_in_col);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_win[a*3+0] = r_win[a*3+1];
            n_win[a*3+1] = r_win[a*3+2];
        end
        n_win[2] = r_rd.older;
        n_win[5] = r_rd.newer;
        n_win[8] = r_s1_pix;
    end

    assign o_push        = s1_adv && r_s1_emit;
    assign o_job.win     = n_win;
    assign o_job.x_first = r_s1_xf;
    assign o_job.x_last  = r_s1_xl;
    assign o_job.y_first = r_s1_yf;
    assign o_job.y_last  = r_s1_yl;
    assign o_job.last    = r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_m1     <= CW'(W_RST - 1);
            r_h_m1     <= HW'(H_RST - 1);
            r_in_col   <= '0;
            r_rows     <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == sbd_pkg::REG_IMAGE_WIDTH) begin
                    r_w_m1    <= n_w_m1;
                    r_in_col  <= '0;
                    r_rows    <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else if (i_cfg_index == sbd_pkg::REG_IMAGE_HEIGHT) begin
                    r_h_m1    <= n_h_m1;
                    r_in_col  <= '0;
                    r_rows    <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end
            end else if (acc) begin
                if (last) begin
                    r_in_col  <= '0;
                    r_rows    <= '0;
                    r_out_col <= '0;
                    r_out_row <= '0;
                end else begin
                    if (r_in_col == r_w_m1) begin
                        r_in_col <= '0;
                        if (r_rows != 2'd2) begin
                            r_rows <= r_rows + 2'd1;
                        end
                    end else begin
                        r_in_col <= r_in_col + 1'b1;
                    end
                    if (emit) begin
                        if (x_last) begin
                            r_out_col <= '0;
                            r_out_row <= r_out_row + 1'b1;
                        end else begin
                            r_out_col <= r_out_col + 1'b1;
                        end
                    end
                end
            end
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_addr <= r_in_col;
            r_s1_pix  <= pix;
            r_s1_emit <= emit;
            r_s1_xf   <= (r_out_col == '0);
            r_s1_xl   <= x_last;
            r_s1_yf   <= (r_out_row == '0);
            r_s1_yl   <= y_last;
            r_s1_last <= last;
        end
    end

    // line buffer pair, write-back forwarded when the same column follows at once
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_mem[r_s1_addr] <= wb;
        end
        if (acc) begin
            r_rd <= bypass ? wb : r_mem[r_in_col];
        end
    end

endmodule

@@ src/sbd_queue.sv @@
// short job queue between the front and back parts
// depends on sbd_pkg
module sbd_queue #(
    parameter int DEPTH = sbd_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sbd_pkg::t_job   i_job,
    input  logic            i_pop,
    output sbd_pkg::t_qstat o_stat,
    output logic            o_head_valid,
    output sbd_pkg::t_job   o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    sbd_pkg::t_job r_q [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [NW-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == NW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head_valid = !o_stat.empty;
    assign o_head       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr] <= i_job;
        end
    end

endmodule

@@ src/sbd_back.sv @@
// back part: clamped neighbor pick, boundary test and output register
// depends on sbd_pkg
module sbd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  sbd_pkg::t_job i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    output sbd_pkg::t_out o_out,
    input  logic          i_out_stall
);

    sbd_pkg::t_rgb t [sbd_pkg::WIN_SIZE];
    logic [9:0]    s [sbd_pkg::WIN_SIZE];
    sbd_pkg::t_rgb best, res;
    logic [9:0]    best_sum;
    logic          any_black, any_lit, repl;
    logic          r_valid;
    sbd_pkg::t_out r_out;

    // neighbors in dx-outer, dy-inner order, edges replicated
    always_comb begin
        int col, row;
        for (int n = 0; n < sbd_pkg::WIN_SIZE; n++) begin
            col = n / 3;
            row = n % 3;
            if ((col == 0 && i_head.x_first) || (col == 2 && i_head.x_last)) begin
                col = 1;
            end
            if ((row == 0 && i_head.y_first) || (row == 2 && i_head.y_last)) begin
                row = 1;
            end
            t[n] = i_head.win[row*3 + col];
            s[n] = 10'(t[n].r) + 10'(t[n].g) + 10'(t[n].b);
        end
    end

    // first maximum wins ties
    always_comb begin
        best      = '0;
        best_sum  = '0;
        any_black = 1'b0;
        any_lit   = 1'b0;
        for (int n = 0; n < sbd_pkg::WIN_SIZE; n++) begin
            if (s[n] == '0) begin
                any_black = 1'b1;
            end else begin
                any_lit = 1'b1;
            end
            if (s[n] > best_sum) begin
                best_sum = s[n];
                best     = t[n];
            end
        end
        repl = any_black && any_lit;
        res  = repl ? best : i_head.win[4];
    end

    assign o_pop       = i_head_valid && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out.out_red       <= res.r;
            r_out.out_green     <= res.g;
            r_out.out_blue      <= res.b;
            r_out.was_replaced  <= repl;
            r_out.last_of_frame <= i_head.last;
        end
    end

endmodule
